/* rtl/mma_pkg.sv */
// Shared types and constants of the matrix multiply-accumulate block.
`default_nettype none

package mma_pkg;

   // Command codes of an input word
   localparam logic [1:0] CMD_LOAD_A    = 2'd0;
   localparam logic [1:0] CMD_LOAD_B    = 2'd1;
   localparam logic [1:0] CMD_LOAD_BIAS = 2'd2;
   localparam logic [1:0] CMD_START     = 2'd3;

   // Transpose modes; the unused code acts as no transpose
   localparam logic [1:0] TMODE_NONE = 2'd0;
   localparam logic [1:0] TMODE_A_T  = 2'd1;
   localparam logic [1:0] TMODE_B_T  = 2'd2;

   // Register numbers on the APB port (byte address is 4 times this)
   localparam logic [2:0] REG_ROWS_N    = 3'd0;
   localparam logic [2:0] REG_INNER_K   = 3'd1;
   localparam logic [2:0] REG_COLS_M    = 3'd2;
   localparam logic [2:0] REG_TRANSPOSE = 3'd3;
   localparam logic [2:0] REG_ADD_BIAS  = 3'd4;

   localparam int ELEM_W     = 32;
   localparam int ROWCOL_W   = 3;
   localparam int INDEX_W    = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic [1:0]                cmd;
      logic [INDEX_W-1:0]        index;
      logic signed [ELEM_W-1:0]  value;
   } mma_req_type;

   typedef struct packed {
      logic [ROWCOL_W-1:0]       row;
      logic [ROWCOL_W-1:0]       col;
      logic signed [ELEM_W-1:0]  result_value;
      logic                      saturated;
      logic                      last;
   } mma_rsp_type;

   typedef struct packed {
      logic [3:0] rows_n;
      logic [3:0] inner_k;
      logic [3:0] cols_m;
      logic [1:0] transpose_mode;
      logic       add_bias;
   } mma_cfg_type;

   // Control that travels with each multiply-accumulate step
   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last_t;
      logic                last_elem;
      logic [ROWCOL_W-1:0] row;
      logic [ROWCOL_W-1:0] col;
   } mma_tag_type;

endpackage

`default_nettype wire

/* rtl/mma_mem.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module mma_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one word into the registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/mma_seq.sv */
// Step sequencer: walks rows, columns and inner index and forms store addresses.
`default_nettype none

module mma_seq #(
   parameter int MAX_DIM = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 go,
   input  wire logic                                 done,
   input  wire mma_pkg::mma_cfg_type                 cfg,
   output logic                                      busy,
   output mma_pkg::mma_tag_type                      tag,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        a_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        b_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        c_addr
);
   import mma_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   // Zero acts as one, anything above the maximum as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] d);
      logic [DIM_W-1:0] r;
      if (d == 4'd0) begin
         r = DIM_W'(1);
      end else if (d > 4'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(d);
      end
      return r;
   endfunction

   logic             run_ff, run_in;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] t_ff, t_in;

   logic [DIM_W-1:0] n_dim, k_dim, m_dim;
   logic             t_end, j_end, i_end;
   logic             a_trans, b_trans;

   assign n_dim = clamp_dim(cfg.rows_n);
   assign k_dim = clamp_dim(cfg.inner_k);
   assign m_dim = clamp_dim(cfg.cols_m);

   assign t_end = (t_ff == CNT_W'(k_dim - DIM_W'(1)));
   assign j_end = (j_ff == CNT_W'(m_dim - DIM_W'(1)));
   assign i_end = (i_ff == CNT_W'(n_dim - DIM_W'(1)));

   assign a_trans = (cfg.transpose_mode == TMODE_A_T);
   assign b_trans = (cfg.transpose_mode == TMODE_B_T);

   // Advance the inner index, then the column, then the row
   always_comb begin
      run_in  = run_ff;
      busy_in = busy_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      t_in    = t_ff;
      if (go) begin
         run_in  = 1'b1;
         busy_in = 1'b1;
         i_in    = '0;
         j_in    = '0;
         t_in    = '0;
      end else begin
         if (run_ff) begin
            if (!t_end) begin
               t_in = t_ff + CNT_W'(1);
            end else begin
               t_in = '0;
               if (!j_end) begin
                  j_in = j_ff + CNT_W'(1);
               end else begin
                  j_in = '0;
                  if (!i_end) begin
                     i_in = i_ff + CNT_W'(1);
                  end else begin
                     run_in = 1'b0;
                  end
               end
            end
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         busy_ff <= 1'b0;
         i_ff    <= '0;
         j_ff    <= '0;
         t_ff    <= '0;
      end else begin
         run_ff  <= run_in;
         busy_ff <= busy_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         t_ff    <= t_in;
      end
   end

   assign busy = busy_ff;

   // Tag the current step
   always_comb begin
      tag.valid     = run_ff;
      tag.first     = (t_ff == '0);
      tag.last_t    = t_end;
      tag.last_elem = t_end && j_end && i_end;
      tag.row       = ROWCOL_W'(i_ff);
      tag.col       = ROWCOL_W'(j_ff);
   end

   // Row-major addresses of the operands and the bias entry
   always_comb begin
      if (a_trans) begin
         a_addr = ADDR_W'(t_ff) * ADDR_W'(n_dim) + ADDR_W'(i_ff);
      end else begin
         a_addr = ADDR_W'(i_ff) * ADDR_W'(k_dim) + ADDR_W'(t_ff);
      end
      if (b_trans) begin
         b_addr = ADDR_W'(j_ff) * ADDR_W'(k_dim) + ADDR_W'(t_ff);
      end else begin
         b_addr = ADDR_W'(t_ff) * ADDR_W'(m_dim) + ADDR_W'(j_ff);
      end
      c_addr = ADDR_W'(i_ff) * ADDR_W'(m_dim) + ADDR_W'(j_ff);
   end

endmodule

`default_nettype wire

/* rtl/mma_mac.sv */
// Multiply-accumulate pipeline with bias preload, floor shift and saturation.
`default_nettype none

module mma_mac #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               add_bias,
   input  wire mma_pkg::mma_tag_type               tag,
   input  wire logic signed [mma_pkg::ELEM_W-1:0]  a_rd,
   input  wire logic signed [mma_pkg::ELEM_W-1:0]  b_rd,
   input  wire logic signed [mma_pkg::ELEM_W-1:0]  c_rd,
   output logic                                    rsp_valid,
   output mma_pkg::mma_rsp_type                    rsp_data
);
   import mma_pkg::*;

   localparam int PROD_W = 2 * ELEM_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

   mma_tag_type              tag1_ff, tag2_ff, tag3_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  bterm_ff, bterm_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  shifted;
   logic                     fits;
   logic                     rsp_valid_ff, rsp_valid_in;
   mma_rsp_type              rsp_data_ff, rsp_data_in;

   // Multiply the operands; scale the bias to the product's binary point
   assign prod_in  = PROD_W'(a_rd) * PROD_W'(b_rd);
   assign bterm_in = add_bias ? (ACC_W'(c_rd) <<< FRAC_BITS) : '0;

   // Start each element from the bias term, else keep summing
   always_comb begin
      acc_in = acc_ff;
      if (tag2_ff.valid) begin
         acc_in = (tag2_ff.first ? bterm_ff : acc_ff) + ACC_W'(prod_ff);
      end
   end

   // Shift down to Q16.16 and clip to 32 bits
   assign shifted = acc_ff >>> FRAC_BITS;
   assign fits    = (&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]);

   always_comb begin
      rsp_valid_in          = tag3_ff.valid && tag3_ff.last_t;
      rsp_data_in.row       = tag3_ff.row;
      rsp_data_in.col       = tag3_ff.col;
      rsp_data_in.last      = tag3_ff.last_elem;
      rsp_data_in.saturated = !fits;
      if (fits) begin
         rsp_data_in.result_value = shifted[ELEM_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         rsp_data_in.result_value = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         rsp_data_in.result_value = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

   // Advance the step tags alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff      <= tag;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      bterm_ff    <= bterm_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/matrix_multiply_accumulate.sv */
// Top level of the matrix multiply-accumulate block: stores, registers, sequencer, datapath.
//
//   channel   ports                                 direction  handshake
//   request   start, busy, req_data                 in         start && !busy
//   response  rsp_valid, rsp_data                   out        rsp_valid, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,  in/out     APB, pready tied high
//             prdata, pready
//
// A load is written to its store without raising busy; the next word may follow at once.
// A start runs N*M*K multiply-accumulate steps, one per cycle through the single
// 32x32 multiplier, and busy falls once the final result has left.
// Results leave in row-major order, one per element as its sum completes, the final one marked last.
// Results cannot be held off; only the sender waits, on busy.
// Reset is synchronous; registers return to their defaults, store contents are kept.
`default_nettype none

module matrix_multiply_accumulate #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire mma_pkg::mma_req_type               req_data,
   output logic                                    rsp_valid,
   output mma_pkg::mma_rsp_type                    rsp_data,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [mma_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [mma_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [mma_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                    pready
);
   import mma_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [3:0]  rows_n_ff, inner_k_ff, cols_m_ff;
   logic [1:0]  transpose_ff;
   logic        add_bias_ff;
   logic        csr_wr;
   logic [2:0]  csr_sel;

   mma_cfg_type cfg;
   mma_tag_type tag;
   logic        go, load, in_range, done;
   logic [ADDR_W-1:0] a_addr, b_addr, c_addr, wr_addr;
   logic [ELEM_W-1:0] a_rd, b_rd, c_rd;

   // Register file
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_n_ff    <= 4'd8;
         inner_k_ff   <= 4'd8;
         cols_m_ff    <= 4'd8;
         transpose_ff <= TMODE_NONE;
         add_bias_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_sel)
            REG_ROWS_N:    rows_n_ff    <= pwdata[3:0];
            REG_INNER_K:   inner_k_ff   <= pwdata[3:0];
            REG_COLS_M:    cols_m_ff    <= pwdata[3:0];
            REG_TRANSPOSE: transpose_ff <= pwdata[1:0];
            REG_ADD_BIAS:  add_bias_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_ROWS_N:    prdata = CSR_DATA_W'(rows_n_ff);
         REG_INNER_K:   prdata = CSR_DATA_W'(inner_k_ff);
         REG_COLS_M:    prdata = CSR_DATA_W'(cols_m_ff);
         REG_TRANSPOSE: prdata = CSR_DATA_W'(transpose_ff);
         REG_ADD_BIAS:  prdata = CSR_DATA_W'(add_bias_ff);
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      cfg.rows_n         = rows_n_ff;
      cfg.inner_k        = inner_k_ff;
      cfg.cols_m         = cols_m_ff;
      cfg.transpose_mode = transpose_ff;
      cfg.add_bias       = add_bias_ff;
   end

   // Decode the accepted word; drop loads beyond the store
   assign go       = start && !busy && (req_data.cmd == CMD_START);
   assign load     = start && !busy && (req_data.cmd != CMD_START);
   assign in_range = ({1'b0, req_data.index} < (INDEX_W + 1)'(DEPTH));
   assign wr_addr  = req_data.index[ADDR_W-1:0];
   assign done     = rsp_valid && rsp_data.last;

   mma_mem #(.DEPTH(DEPTH), .WIDTH(ELEM_W)) u_a_store (
      .clock   (clock),
      .wr_en   (load && in_range && (req_data.cmd == CMD_LOAD_A)),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_addr (a_addr),
      .rd_data (a_rd)
   );

   mma_mem #(.DEPTH(DEPTH), .WIDTH(ELEM_W)) u_b_store (
      .clock   (clock),
      .wr_en   (load && in_range && (req_data.cmd == CMD_LOAD_B)),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_addr (b_addr),
      .rd_data (b_rd)
   );

   mma_mem #(.DEPTH(DEPTH), .WIDTH(ELEM_W)) u_bias_store (
      .clock   (clock),
      .wr_en   (load && in_range && (req_data.cmd == CMD_LOAD_BIAS)),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_addr (c_addr),
      .rd_data (c_rd)
   );

   mma_seq #(.MAX_DIM(MAX_DIM)) u_seq (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .done   (done),
      .cfg    (cfg),
      .busy   (busy),
      .tag    (tag),
      .a_addr (a_addr),
      .b_addr (b_addr),
      .c_addr (c_addr)
   );

   mma_mac #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .add_bias  (add_bias_ff),
      .tag       (tag),
      .a_rd      (a_rd),
      .b_rd      (b_rd),
      .c_rd      (c_rd),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/mma_checker.sv */
// Port-level checks of the matrix multiply-accumulate block, bound to the top level.
`default_nettype none

module mma_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire mma_pkg::mma_req_type req_data,
   input wire logic                 rsp_valid,
   input wire mma_pkg::mma_rsp_type rsp_data
);
   import mma_pkg::*;

   // Results appear only during a run
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result word outside a run");

   // The final result ends the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !busy)
      else $error("still busy after final result");

   // A result that is not final keeps the run going
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> busy)
      else $error("run ended before final result");

   // A start begins a run, a load does not
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.cmd == CMD_START) |=> busy)
      else $error("start word did not begin a run");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.cmd != CMD_START) |=> !busy)
      else $error("load word made the block busy");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* verif/matrix_multiply_accumulate_tb.sv */
// Self-checking testbench of the matrix multiply-accumulate block with a scoreboard.
import mma_pkg::*;

class gemm_scoreboard;
   localparam int     FRAC_BITS = 16;
   localparam int     STORE_DEPTH = 64;
   localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SAT_LO = 64'shFFFF_FFFF_8000_0000;

   logic [31:0]  elem_store [3][STORE_DEPTH];
   bit           elem_filled [3][STORE_DEPTH];
   mma_cfg_type  cfg;
   mma_rsp_type  pending_elems [$];
   int unsigned  mismatch_count;

   function new();
      cfg = '{rows_n: 4'd8, inner_k: 4'd8, cols_m: 4'd8,
              transpose_mode: TMODE_NONE, add_bias: 1'b0};
      mismatch_count = 0;
   endfunction

   function int unsigned clamp_dim(logic [3:0] d);
      if (d == 4'd0) return 1;
      if (d > 4'd8) return 8;
      return d;
   endfunction

   function void write_reg(logic [2:0] regnum, logic [31:0] data);
      case (regnum)
         REG_ROWS_N:    cfg.rows_n = data[3:0];
         REG_INNER_K:   cfg.inner_k = data[3:0];
         REG_COLS_M:    cfg.cols_m = data[3:0];
         REG_TRANSPOSE: cfg.transpose_mode = data[1:0];
         REG_ADD_BIAS:  cfg.add_bias = data[0];
         default: ;
      endcase
   endfunction

   // Queue every element of R = op(A) * op(B) (+ bias) in row-major order
   function void compute_product();
      int unsigned       n, k, m, i, j, t;
      logic [1:0]        mode;
      logic [5:0]        ai, bi;
      logic signed [79:0] acc, bias_term;
      longint            prod, scaled;
      mma_rsp_type       e;
      n = clamp_dim(cfg.rows_n);
      k = clamp_dim(cfg.inner_k);
      m = clamp_dim(cfg.cols_m);
      mode = (cfg.transpose_mode == TMODE_A_T || cfg.transpose_mode == TMODE_B_T) ?
             cfg.transpose_mode : TMODE_NONE;
      for (i = 0; i < n; i++) begin
         for (j = 0; j < m; j++) begin
            acc = '0;
            for (t = 0; t < k; t++) begin
               ai = (mode == TMODE_A_T) ? 6'(t * n + i) : 6'(i * k + t);
               bi = (mode == TMODE_B_T) ? 6'(j * k + t) : 6'(t * m + j);
               prod = longint'($signed(elem_store[CMD_LOAD_A][ai])) *
                      longint'($signed(elem_store[CMD_LOAD_B][bi]));
               acc = acc + prod;
            end
            if (cfg.add_bias) begin
               bias_term = $signed(elem_store[CMD_LOAD_BIAS][6'(i * m + j)]);
               bias_term = bias_term <<< FRAC_BITS;
               acc = acc + bias_term;
            end
            // Floor shift, then clip to signed 32 bits
            acc = acc >>> FRAC_BITS;
            scaled = acc[63:0];
            e.row = 3'(i);
            e.col = 3'(j);
            if (scaled > SAT_HI) begin
               e.result_value = 32'sh7FFF_FFFF;
               e.saturated = 1'b1;
            end else if (scaled < SAT_LO) begin
               e.result_value = 32'sh8000_0000;
               e.saturated = 1'b1;
            end else begin
               e.result_value = scaled[31:0];
               e.saturated = 1'b0;
            end
            e.last = (i == n - 1 && j == m - 1);
            pending_elems.push_back(e);
         end
      end
   endfunction

   function void note_request(mma_req_type w);
      if (w.cmd == CMD_START) begin
         compute_product();
      end else begin
         elem_store[w.cmd][w.index] = w.value;
         elem_filled[w.cmd][w.index] = 1'b1;
      end
   endfunction

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   task check_result(mma_rsp_type got);
      mma_rsp_type want;
      if (pending_elems.size() == 0) begin
         report_mismatch($sformatf("result (%0d,%0d) with none expected", got.row, got.col));
         return;
      end
      want = pending_elems.pop_front();
      if (got.row !== want.row)
         report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
         report_mismatch($sformatf("col %0d, expected %0d", got.col, want.col));
      if (got.result_value !== want.result_value)
         report_mismatch($sformatf("(%0d,%0d) value %h, expected %h", want.row, want.col,
                                   got.result_value, want.result_value));
      if (got.saturated !== want.saturated)
         report_mismatch($sformatf("(%0d,%0d) saturated %b, expected %b", want.row, want.col,
                                   got.saturated, want.saturated));
      if (got.last !== want.last)
         report_mismatch($sformatf("(%0d,%0d) last %b, expected %b", want.row, want.col,
                                   got.last, want.last));
   endtask
endclass

module matrix_multiply_accumulate_tb;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned WORD_TARGET = 260;
   localparam int unsigned SETTLE_CYCLES = 12;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   mma_req_type           req_data;
   logic                  rsp_valid;
   mma_rsp_type           rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   gemm_scoreboard sb = new();
   int unsigned    cycle_count = 0;
   int unsigned    words_sent = 0;
   bit             steady = 1'b0;

   matrix_multiply_accumulate u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Check each result word at the edge that takes it
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   function automatic logic [31:0] rand_elem();
      logic [17:0] frac;
      frac = 18'($urandom);
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3, 4, 5: return {{14{frac[17]}}, frac};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [3:0] pick_dim();
      case ($urandom_range(0, 19))
         0: return 4'd0;
         1: return 4'($urandom_range(9, 15));
         2, 3: return 4'd8;
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic csr_write(logic [2:0] regnum, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {regnum, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(regnum, data);
      // Return the bus to idle
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the word until the block takes it
   task automatic send_word(mma_req_type w);
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      sb.note_request(w);
      words_sent++;
   endtask

   task automatic load_elem(logic [1:0] c, logic [5:0] idx, logic [31:0] v);
      send_word('{cmd: c, index: idx, value: v});
   endtask

   task automatic issue_start();
      send_word('{cmd: CMD_START, index: 6'($urandom), value: $urandom});
   endtask

   // Drop start for a random gap, mostly short, with junk on the data bus
   task automatic pause_sender();
      int unsigned r, gap;
      r = $urandom_range(0, 99);
      gap = (steady || r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         req_data <= '{cmd: 2'($urandom), index: 6'($urandom), value: $urandom};
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait for every expected word, then let the block settle
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_elems.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Load every entry the next product reads that has not been written yet
   task automatic fill_needed();
      int unsigned n, k, m, idx;
      n = sb.clamp_dim(sb.cfg.rows_n);
      k = sb.clamp_dim(sb.cfg.inner_k);
      m = sb.clamp_dim(sb.cfg.cols_m);
      for (idx = 0; idx < n * k; idx++)
         if (!sb.elem_filled[CMD_LOAD_A][idx]) begin
            pause_sender();
            load_elem(CMD_LOAD_A, 6'(idx), rand_elem());
         end
      for (idx = 0; idx < k * m; idx++)
         if (!sb.elem_filled[CMD_LOAD_B][idx]) begin
            pause_sender();
            load_elem(CMD_LOAD_B, 6'(idx), rand_elem());
         end
      if (sb.cfg.add_bias)
         for (idx = 0; idx < n * m; idx++)
            if (!sb.elem_filled[CMD_LOAD_BIAS][idx]) begin
               pause_sender();
               load_elem(CMD_LOAD_BIAS, 6'(idx), rand_elem());
            end
   endtask

   // Reload part of the operands, then multiply; now and then wait it out
   task automatic run_product(int unsigned loads);
      logic [1:0]  c;
      int unsigned n, k, m, span;
      n = sb.clamp_dim(sb.cfg.rows_n);
      k = sb.clamp_dim(sb.cfg.inner_k);
      m = sb.clamp_dim(sb.cfg.cols_m);
      repeat (loads) begin
         c = 2'($urandom_range(CMD_LOAD_A, CMD_LOAD_BIAS));
         span = (c == CMD_LOAD_A) ? n * k : (c == CMD_LOAD_B) ? k * m : n * m;
         if ($urandom_range(0, 4) == 0) span = 64;
         pause_sender();
         load_elem(c, 6'($urandom_range(0, span - 1)), rand_elem());
      end
      fill_needed();
      pause_sender();
      issue_start();
      if ($urandom_range(0, 7) == 0) drain();
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 2x2x2 with extreme operands, both saturation signs, bias on
      csr_write(REG_ROWS_N, 32'd2);
      csr_write(REG_INNER_K, 32'd2);
      csr_write(REG_COLS_M, 32'd2);
      csr_write(REG_TRANSPOSE, 32'(TMODE_NONE));
      csr_write(REG_ADD_BIAS, 32'd1);
      load_elem(CMD_LOAD_A, 6'd0, 32'h7FFF_FFFF);
      load_elem(CMD_LOAD_A, 6'd1, 32'h7FFF_FFFF);
      load_elem(CMD_LOAD_A, 6'd2, 32'h8000_0000);
      load_elem(CMD_LOAD_A, 6'd3, 32'h0001_0000);
      load_elem(CMD_LOAD_B, 6'd0, 32'h7FFF_FFFF);
      load_elem(CMD_LOAD_B, 6'd1, 32'h8000_0000);
      load_elem(CMD_LOAD_B, 6'd2, 32'h7FFF_FFFF);
      load_elem(CMD_LOAD_B, 6'd3, 32'hFFFF_0000);
      load_elem(CMD_LOAD_BIAS, 6'd0, 32'h7FFF_FFFF);
      load_elem(CMD_LOAD_BIAS, 6'd1, 32'h8000_0000);
      load_elem(CMD_LOAD_BIAS, 6'd2, 32'h0000_0000);
      load_elem(CMD_LOAD_BIAS, 6'd63, 32'hFFFF_FFFF);
      load_elem(CMD_LOAD_BIAS, 6'd3, 32'hFFFF_FFFF);
      send_word('{cmd: CMD_START, index: 6'h3F, value: 32'hFFFF_FFFF});
      drain();

      // Directed: bias off, then each transpose mode on the same operands
      csr_write(REG_ADD_BIAS, 32'd0);
      send_word('{cmd: CMD_START, index: 6'h00, value: 32'h0000_0000});
      drain();
      csr_write(REG_TRANSPOSE, 32'(TMODE_A_T));
      issue_start();
      drain();
      csr_write(REG_TRANSPOSE, 32'(TMODE_B_T));
      issue_start();
      drain();

      // Directed: zero rows act as one, oversize columns as eight, unused transpose code
      csr_write(REG_ROWS_N, 32'd0);
      csr_write(REG_COLS_M, 32'd15);
      csr_write(REG_TRANSPOSE, 32'd3);
      fill_needed();
      issue_start();
      drain();

      // Random: new settings per phase, a few well-formed products per phase
      while (words_sent < WORD_TARGET) begin
         csr_write(REG_ROWS_N, 32'(pick_dim()));
         csr_write(REG_INNER_K, 32'(pick_dim()));
         csr_write(REG_COLS_M, 32'(pick_dim()));
         csr_write(REG_TRANSPOSE, 32'($urandom_range(0, 3)));
         csr_write(REG_ADD_BIAS, 32'($urandom_range(0, 1)));
         steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 4)) run_product($urandom_range(0, 6));
         drain();
      end

      if (sb.mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
